@@ design/fba_pkg.sv @@
// Shared types and codes of the frame bitmap allocator.
// Used by fba_front, fba_back and frame_bitmap_allocator_core; no dependencies.
`timescale 1ns / 1ps

package fba_pkg;

    localparam int FRAME_W  = 15;
    localparam int WORD_W   = 32;
    localparam int BIT_IDX_W = 5;
    localparam int FC_W     = 16;
    localparam logic [WORD_W-1:0] WORD_FULL = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NOCHANGE = 2'd1;
    localparam logic [1:0] STATUS_OOM      = 2'd2;

    // request command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register indexes
    localparam int REG_FRAME_COUNT = 0;

    // what the back end has to do with a request
    typedef enum logic [2:0] {
        KIND_MAPPED,    // alloc on a mapped entry: echo frame, no change
        KIND_FREE_NONE, // free of frame zero: no change
        KIND_ALLOC,     // scan for the lowest free frame
        KIND_FREE_IN,   // clear a bit inside the bitmap
        KIND_FREE_OUT   // free beyond the bitmap: report done, no write
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [FRAME_W-1:0] page_frame;
        logic               is_kernel;
        logic               is_writeable;
    } job_t;

    // queue to back end handshake
    typedef struct packed {
        logic valid;
        job_t job;
    } job_q_t;

endpackage

@@ design/fba_ram.sv @@
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/fba_front.sv @@
// Front end: accepts request beats, classifies them and queues them (2 deep).
// Depends on fba_pkg.
`timescale 1ns / 1ps

module fba_front
    import fba_pkg::*;
#(
    parameter int WORDS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // page_frame[14:0], is_kernel[15], is_writeable[16]
    input  logic         s_tuser,   // cmd[0]
    output job_q_t       q_out,
    input  logic         q_pop
);

    job_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    job_t        job_in;
    logic        push;
    logic [9:0]  pf_word;

    // classification of the incoming beat
    assign pf_word = s_tdata[FRAME_W-1:5];

    always_comb begin
        job_in.page_frame   = s_tdata[FRAME_W-1:0];
        job_in.is_kernel    = s_tdata[15];
        job_in.is_writeable = s_tdata[16];
        if (s_tuser == CMD_ALLOC) begin
            job_in.kind = (s_tdata[FRAME_W-1:0] != '0) ? KIND_MAPPED : KIND_ALLOC;
        end else if (s_tdata[FRAME_W-1:0] == '0) begin
            job_in.kind = KIND_FREE_NONE;
        end else if (32'(pf_word) < 32'(WORDS)) begin
            job_in.kind = KIND_FREE_IN;
        end else begin
            job_in.kind = KIND_FREE_OUT;
        end
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.job   = slot_reg[rd_ptr_reg];

    // queue pointers and count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

@@ design/fba_back.sv @@
// Back end: runs queued jobs against the bitmap RAM and drives the result beat.
// Depends on fba_pkg and fba_ram.
`timescale 1ns / 1ps

module fba_back
    import fba_pkg::*;
#(
    parameter int WORDS = 1024,
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [FC_W-1:0] frame_count,
    input  job_q_t          q_in,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,  // present[0], writable[1], user_page[2], frame[17:3]
    output logic [1:0]      m_tuser   // status[1:0]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [AW:0]         hwm_reg;      // words at and above this index are all zero
    logic [AW:0]         lim_reg;
    logic [AW:0]         rd_w_reg;
    logic                dv_reg;
    logic [AW:0]         dw_reg;
    logic [1:0]          status_reg;
    logic                present_reg;
    logic                writable_reg;
    logic                user_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic [10:0]         fc_words;
    logic [AW:0]         limit;
    logic [AW-1:0]       free_w;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   word_seen;
    logic [WORD_W-1:0]   zero_onehot;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                found;
    logic                out_free;

    fba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan limit: whole words below frame_count, capped at the bitmap size
    assign fc_words = frame_count[FC_W-1:5];
    assign limit = (32'(fc_words) >= 32'(WORDS)) ? (AW+1)'(WORDS) : (AW+1)'(fc_words);

    assign free_w = AW'(job_reg.page_frame[FRAME_W-1:5]);

    // returned word, untouched words read as zero
    assign word_seen = (dw_reg < hwm_reg) ? ram_rdata : '0;

    // lowest clear bit of the returned word
    assign zero_onehot = ~word_seen & (word_seen + 32'd1);
    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            bit_idx = bit_idx | (zero_onehot[i] ? BIT_IDX_W'(i) : '0);
        end
    end

    assign found = (state_reg == S_SCAN) && dv_reg && (word_seen != WORD_FULL);

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = dw_reg[AW-1:0];
        ram_wdata = word_seen | zero_onehot;
        ram_raddr = rd_w_reg[AW-1:0];
        if (state_reg == S_FREE_RD) begin
            ram_raddr = free_w;
        end
        if (found) begin
            ram_we = 1'b1;
        end else if (state_reg == S_FREE_WR) begin
            ram_we    = 1'b1;
            ram_waddr = free_w;
            ram_wdata = ram_rdata & ~(32'd1 << job_reg.page_frame[4:0]);
        end
    end

    assign q_pop    = (state_reg == S_IDLE) && q_in.valid;
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer, bitmap fill count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hwm_reg      <= '0;
            dv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the done state reloads the result register itself
            if (m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_in.valid) begin
                        job_reg      <= q_in.job;
                        present_reg  <= 1'b0;
                        writable_reg <= 1'b0;
                        user_reg     <= 1'b0;
                        frame_reg    <= (q_in.job.kind == KIND_MAPPED) ?
                                        q_in.job.page_frame : '0;
                        rd_w_reg     <= '0;
                        dv_reg       <= 1'b0;
                        lim_reg      <= limit;
                        unique case (q_in.job.kind)
                            KIND_MAPPED: begin
                                status_reg <= STATUS_NOCHANGE;
                                state_reg  <= S_DONE;
                            end
                            KIND_FREE_NONE: begin
                                status_reg <= STATUS_NOCHANGE;
                                state_reg  <= S_DONE;
                            end
                            KIND_ALLOC: begin
                                if (limit == '0) begin
                                    status_reg <= STATUS_OOM;
                                    state_reg  <= S_DONE;
                                end else begin
                                    status_reg <= STATUS_DONE;
                                    state_reg  <= S_SCAN;
                                end
                            end
                            KIND_FREE_IN: begin
                                status_reg <= STATUS_DONE;
                                // an untouched word is already clear
                                if ((AW+1)'(q_in.job.page_frame[FRAME_W-1:5]) < hwm_reg) begin
                                    state_reg <= S_FREE_RD;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            KIND_FREE_OUT: begin
                                status_reg <= STATUS_DONE;
                                state_reg  <= S_DONE;
                            end
                            default: begin
                                status_reg <= STATUS_DONE;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // one read issued and one word checked per cycle
                    if (found) begin
                        status_reg   <= STATUS_DONE;
                        present_reg  <= 1'b1;
                        writable_reg <= job_reg.is_writeable;
                        user_reg     <= ~job_reg.is_kernel;
                        frame_reg    <= FRAME_W'({dw_reg[AW-1:0], bit_idx});
                        if (dw_reg == hwm_reg) begin
                            hwm_reg <= hwm_reg + 1'b1;
                        end
                        dv_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (dv_reg && (dw_reg + 1'b1 == lim_reg)) begin
                        status_reg <= STATUS_OOM;
                        dv_reg     <= 1'b0;
                        state_reg  <= S_DONE;
                    end else if (rd_w_reg < lim_reg) begin
                        dv_reg   <= 1'b1;
                        dw_reg   <= rd_w_reg;
                        rd_w_reg <= rd_w_reg + 1'b1;
                    end else begin
                        dv_reg <= 1'b0;
                    end
                end
                S_FREE_RD: begin
                    state_reg <= S_FREE_WR;
                end
                S_FREE_WR: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {6'd0, frame_reg, user_reg, writable_reg, present_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // fill count never passes the bitmap size
    a_hwm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= (AW+1)'(WORDS))
        else $error("fill count beyond bitmap");

    // a returned scan word always lies below the scan limit
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && dv_reg) |-> (dw_reg < lim_reg))
        else $error("scan word beyond limit");

    // the fill count only moves on an allocation write
    a_hwm_moves_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (hwm_reg != $past(hwm_reg)) |-> $past(found))
        else $error("fill count changed without allocation");

    // out of memory and no-change results never carry page bits
    a_status_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg != STATUS_DONE) |-> !present_reg && !user_reg)
        else $error("page bits set on failed request");

endmodule

@@ design/frame_bitmap_allocator_core.sv @@
// Top level of the frame bitmap allocator: APB register, front end queue, back end.
// Depends on fba_pkg, fba_front, fba_back and fba_ram.
`timescale 1ns / 1ps

// First-fit physical frame allocator over a bitmap of NUM_FRAMES bits held in a
// 32-bit wide RAM of NUM_FRAMES/32 words, all frames free after reset (a fill count
// stands in for clearing, so the block is usable from the first cycle). One result
// beat per request beat, in order. An allocation reads one bitmap word per cycle
// through the RAM's single read port, from word 0 upwards, and reports out of
// memory when no word below limit holds a free frame, where limit is
// min(frame_count/32, NUM_FRAMES/32). A free of a frame in an already written word
// reads, modifies and writes that one word; other frees and no-change requests
// write no word. A 2-deep request queue keeps taking beats, until it is full,
// while the back end works or a result waits on m_tready. frame_count sits at
// address 0 of the APB port and is to be written only while the block is idle.

module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // page_frame[14:0], is_kernel[15], is_writeable[16]
    input  logic        s_tuser,   // cmd[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // present[0], writable[1], user_page[2], frame[17:3]
    output logic [1:0]  m_tuser,   // status[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS = NUM_FRAMES / 32;

    logic [FC_W-1:0] frame_count_reg;
    logic            cfg_wr;
    job_q_t          q_bus;
    logic            q_pop;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= 16'd32768;
        end else if (cfg_wr && (32'(paddr >> 2) == REG_FRAME_COUNT)) begin
            frame_count_reg <= pwdata[FC_W-1:0];
        end
    end

    assign prdata = (32'(paddr >> 2) == REG_FRAME_COUNT) ? {16'd0, frame_count_reg} : 32'd0;

    fba_front #(
        .WORDS (WORDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_out    (q_bus),
        .q_pop    (q_pop)
    );

    fba_back #(
        .WORDS (WORDS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_count (frame_count_reg),
        .q_in        (q_bus),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
